### rtl/core/tsfs_pkg.sv
// shared types, constants and the cordic angle table for the trapezoid solver
package tsfs_pkg;

  localparam int SIDE_W      = 16;
  localparam int PERIM_W     = 18;
  localparam int AREA_W      = 32;
  localparam int ANGLE_W     = 16;
  localparam int NUM_W       = 70;
  localparam int ROOT_W      = 35;
  localparam int MAG_W       = 34;
  localparam int LANE_W      = 36;
  localparam int Z_W         = 34;
  localparam int SQRT_CELLS  = NUM_W / 2;
  localparam int DIV_CELLS   = SIDE_W;
  localparam int NORM_CELLS  = 6;
  localparam int NORM_BITS   = 30;
  localparam int CORDIC_STEPS = 30;

  localparam logic [ANGLE_W-1:0] DEG180 = ANGLE_W'(180 << 8);
  localparam logic [ANGLE_W-1:0] DEG90  = ANGLE_W'(90 << 8);

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EQUAL_BASES = 2'd1,
    ST_OPEN        = 2'd2,
    ST_ZERO_LEG    = 2'd3
  } status_t;

  // front end result: everything derived from the four sides
  typedef struct packed {
    status_t            status;
    logic [PERIM_W-1:0] perim;
    logic [SIDE_W:0]    s;
    logic [SIDE_W-1:0]  d;
    logic               lneg;
    logic [MAG_W-1:0]   lmag;
    logic               rneg;
    logic [MAG_W-1:0]   rmag;
    logic [NUM_W-1:0]   num;
  } front_t;

  // fields that ride alongside the cell rows
  typedef struct packed {
    status_t            status;
    logic [PERIM_W-1:0] perim;
    logic [SIDE_W:0]    s;
    logic [SIDE_W-1:0]  d;
    logic               lneg;
    logic [MAG_W-1:0]   lmag;
    logic               rneg;
    logic [MAG_W-1:0]   rmag;
    logic [SIDE_W-1:0]  h;
    logic [AREA_W-1:0]  area;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0]  rad;
    logic [ROOT_W:0]   rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [ROOT_W-1:0]   rem;
    logic [2*SIDE_W-1:0] dsh;
    logic [SIDE_W-1:0]   q;
  } dv_t;

  typedef struct packed {
    logic signed [LANE_W-1:0] x;
    logic signed [LANE_W-1:0] y;
    logic signed [Z_W-1:0]    z;
    logic                     neg;
    logic                     fix;
    logic [ANGLE_W-1:0]       fixv;
  } lane_t;

  // binary angle of atan(2^-i), full turn is 2^32
  function automatic logic signed [Z_W-1:0] atan_turn(input logic [4:0] idx);
    logic signed [Z_W-1:0] t;
    case (idx)
      5'd0:  t = 34'sd536870912;
      5'd1:  t = 34'sd316933406;
      5'd2:  t = 34'sd167458907;
      5'd3:  t = 34'sd85004756;
      5'd4:  t = 34'sd42667331;
      5'd5:  t = 34'sd21354465;
      5'd6:  t = 34'sd10679838;
      5'd7:  t = 34'sd5340245;
      5'd8:  t = 34'sd2670163;
      5'd9:  t = 34'sd1335087;
      5'd10: t = 34'sd667544;
      5'd11: t = 34'sd333772;
      5'd12: t = 34'sd166886;
      5'd13: t = 34'sd83443;
      5'd14: t = 34'sd41722;
      5'd15: t = 34'sd20861;
      5'd16: t = 34'sd10430;
      5'd17: t = 34'sd5215;
      5'd18: t = 34'sd2608;
      5'd19: t = 34'sd1304;
      5'd20: t = 34'sd652;
      5'd21: t = 34'sd326;
      5'd22: t = 34'sd163;
      5'd23: t = 34'sd81;
      5'd24: t = 34'sd41;
      5'd25: t = 34'sd20;
      5'd26: t = 34'sd10;
      5'd27: t = 34'sd5;
      5'd28: t = 34'sd3;
      5'd29: t = 34'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

### rtl/core/tsfs_front.sv
// front end: status checks, side products and the radicand, three register stages
module tsfs_front (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tsfs_pkg::SIDE_W-1:0] left_leg,
  input  logic [tsfs_pkg::SIDE_W-1:0] right_leg,
  input  logic [tsfs_pkg::SIDE_W-1:0] top_base,
  input  logic [tsfs_pkg::SIDE_W-1:0] bottom_base,
  output tsfs_pkg::front_t          fr_o
);
  import tsfs_pkg::*;

  logic [SIDE_W-1:0]  d;
  logic               dneg;
  logic [SIDE_W+1:0]  f2, f3, f4, sum3;
  status_t            status;

  status_t            status1_r, status2_r;
  logic [PERIM_W-1:0] perim1_r, perim2_r;
  logic [SIDE_W:0]    s1_r, s2_r;
  logic [SIDE_W-1:0]  d1_r, d2_r;
  logic               dneg1_r;
  logic [34:0]        p1_r;
  logic [33:0]        p2_r;
  logic [31:0]        dd_r, ll_r, rr_r;

  logic [51:0]        nlo_r, nhi_r;
  logic               lneg_r, rneg_r;
  logic [MAG_W-1:0]   lmag_r, rmag_r;
  logic [MAG_W-1:0]   sum_l, sum_r, rr34, ll34;
  logic               lneg0, rneg0;

  front_t             fr_r;

  always_comb begin
    dneg = bottom_base < top_base;
    d    = dneg ? (top_base - bottom_base) : (bottom_base - top_base);
    f2   = {2'b0, d} + {2'b0, left_leg} - {2'b0, right_leg};
    f3   = {2'b0, d} - {2'b0, left_leg} + {2'b0, right_leg};
    f4   = {2'b0, left_leg} + {2'b0, right_leg} - {2'b0, d};
    sum3 = {2'b0, d} + {2'b0, left_leg} + {2'b0, right_leg};
    if (left_leg == '0 || right_leg == '0) begin
      status = ST_ZERO_LEG;
    end else if (top_base == bottom_base) begin
      status = ST_EQUAL_BASES;
    end else if (f2[SIDE_W+1] || f3[SIDE_W+1] || f4[SIDE_W+1]) begin
      status = ST_OPEN;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status1_r <= status;
      perim1_r  <= {2'b0, left_leg} + {2'b0, right_leg} + {2'b0, top_base}
                   + {2'b0, bottom_base};
      s1_r      <= {1'b0, top_base} + {1'b0, bottom_base};
      d1_r      <= d;
      dneg1_r   <= dneg;
      p1_r      <= {17'b0, sum3} * {18'b0, f4[SIDE_W:0]};
      p2_r      <= {17'b0, f2[SIDE_W:0]} * {17'b0, f3[SIDE_W:0]};
      dd_r      <= {16'b0, d} * {16'b0, d};
      ll_r      <= {16'b0, left_leg} * {16'b0, left_leg};
      rr_r      <= {16'b0, right_leg} * {16'b0, right_leg};
    end
  end

  // signed offsets scaled by 2d, kept as sign and magnitude
  always_comb begin
    rr34  = {2'b0, rr_r};
    ll34  = {2'b0, ll_r};
    sum_l = {2'b0, dd_r} + {2'b0, ll_r};
    sum_r = {2'b0, dd_r} + {2'b0, rr_r};
    lneg0 = sum_l < rr34;
    rneg0 = sum_r < ll34;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status2_r <= status1_r;
      perim2_r  <= perim1_r;
      s2_r      <= s1_r;
      d2_r      <= d1_r;
      nlo_r     <= {17'b0, p1_r} * {35'b0, p2_r[16:0]};
      nhi_r     <= {17'b0, p1_r} * {35'b0, p2_r[33:17]};
      lneg_r    <= lneg0 ^ dneg1_r;
      lmag_r    <= lneg0 ? (rr34 - sum_l) : (sum_l - rr34);
      rneg_r    <= rneg0 ^ dneg1_r;
      rmag_r    <= rneg0 ? (ll34 - sum_r) : (sum_r - ll34);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fr_r.status <= status2_r;
      fr_r.perim  <= perim2_r;
      fr_r.s      <= s2_r;
      fr_r.d      <= d2_r;
      fr_r.lneg   <= lneg_r;
      fr_r.lmag   <= lmag_r;
      fr_r.rneg   <= rneg_r;
      fr_r.rmag   <= rmag_r;
      fr_r.num    <= {18'b0, nlo_r} + {1'b0, nhi_r, 17'b0};
    end
  end

  assign fr_o = fr_r;

endmodule

### rtl/core/tsfs_sqrt_cell.sv
// one digit cell of the integer square root row
module tsfs_sqrt_cell (
  input  logic          clk,
  input  logic          en,
  input  tsfs_pkg::sq_t sq_i,
  output tsfs_pkg::sq_t sq_o
);
  import tsfs_pkg::*;

  logic [ROOT_W+2:0] rem_t, trial;
  logic              ge;
  sq_t               sq_r;

  always_comb begin
    rem_t = {sq_i.rem, sq_i.rad[NUM_W-1 -: 2]};
    trial = {1'b0, sq_i.root, 2'b01};
    ge    = rem_t >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r.rad  <= {sq_i.rad[NUM_W-3:0], 2'b00};
      sq_r.rem  <= ge ? (ROOT_W+1)'(rem_t - trial) : (ROOT_W+1)'(rem_t);
      sq_r.root <= {sq_i.root[ROOT_W-2:0], ge};
    end
  end

  assign sq_o = sq_r;

endmodule

### rtl/core/tsfs_div_cell.sv
// one quotient bit cell of the height divider row
module tsfs_div_cell (
  input  logic          clk,
  input  logic          en,
  input  tsfs_pkg::dv_t dv_i,
  output tsfs_pkg::dv_t dv_o
);
  import tsfs_pkg::*;

  logic [ROOT_W-1:0] dsh_ext;
  logic              ge;
  dv_t               dv_r;

  always_comb begin
    dsh_ext = {3'b0, dv_i.dsh};
    ge      = dv_i.rem >= dsh_ext;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r.rem <= ge ? (dv_i.rem - dsh_ext) : dv_i.rem;
      dv_r.dsh <= {1'b0, dv_i.dsh[2*SIDE_W-1:1]};
      dv_r.q   <= {dv_i.q[SIDE_W-2:0], ge};
    end
  end

  assign dv_o = dv_r;

endmodule

### rtl/core/tsfs_cordic_cell.sv
// one vectoring step of the cordic row, step number strapped by the row
module tsfs_cordic_cell (
  input  logic            clk,
  input  logic            en,
  input  logic [4:0]      step_i,
  input  tsfs_pkg::lane_t ln_i,
  output tsfs_pkg::lane_t ln_o
);
  import tsfs_pkg::*;

  logic signed [LANE_W-1:0] x, y, dx, dy;
  logic signed [Z_W-1:0]    z, t;
  lane_t                    nxt;
  lane_t                    ln_r;

  always_comb begin
    x   = ln_i.x;
    y   = ln_i.y;
    z   = ln_i.z;
    dx  = y >>> step_i;
    dy  = x >>> step_i;
    t   = atan_turn(step_i);
    nxt = ln_i;
    if (y > 0) begin
      nxt.x = x + dx;
      nxt.y = y - dy;
      nxt.z = z + t;
    end else begin
      nxt.x = x - dx;
      nxt.y = y + dy;
      nxt.z = z - t;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln_r <= nxt;
    end
  end

  assign ln_o = ln_r;

endmodule

### rtl/core/trapezoid_solver_from_sides_top.sv
// top level: front end, square root, divider and cordic cell rows, output register
// throughput: one shape per cycle, every stage of every cell row moves each cycle
// the rows only stall when the output register holds an untaken result and the
// last stage is also full
// reset (synchronous, rst_n low) clears the stage valid bits and the output valid
module trapezoid_solver_from_sides_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // left_leg[15:0], right_leg[31:16], top_base[47:32], bottom_base[63:48]
  input  logic [63:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // height[15:0], perimeter[33:16], area[65:34], angle_bottom_left[81:66],
  // angle_bottom_right[97:82], angle_top_left[113:98], angle_top_right[129:114], zero pad
  output logic [135:0] out_tdata,
  // status[1:0]
  output logic [1:0]   out_tuser
);
  import tsfs_pkg::*;

  localparam int FRONT_STG  = 3;
  localparam int Y_STG      = SQRT_CELLS;
  localparam int DIV_END    = Y_STG + DIV_CELLS;
  localparam int AREA_STG   = DIV_END + 1;
  localparam int VEC_STG    = Y_STG + 1;
  localparam int PRE_STG    = VEC_STG + NORM_CELLS + 1;
  localparam int FIN_STG    = PRE_STG + CORDIC_STEPS + 1;
  localparam int NV         = FRONT_STG + FIN_STG;

  logic              en;
  logic [NV-1:0]     vld_r, vld_nxt;
  logic              out_valid_r;
  logic [135:0]      out_data_r;
  logic [1:0]        out_user_r;

  front_t            fr;
  side_t             side0;
  side_t             side_r   [1:FIN_STG];
  side_t             side_nxt [1:FIN_STG];

  sq_t               sq_c [0:SQRT_CELLS];
  dv_t               dv_c [0:DIV_CELLS];
  logic [ROOT_W-1:0] y_root;
  logic [32:0]       area_prod;

  lane_t             vec_nxt [2];
  lane_t             ln_r    [0:NORM_CELLS][2];
  lane_t             norm_nxt [1:NORM_CELLS][2];
  lane_t             pre_r   [2];
  lane_t             pre_nxt [2];
  lane_t             cd_c    [0:CORDIC_STEPS][2];

  logic [47:0]        prod_r  [2];
  logic               fix_r   [2];
  logic [ANGLE_W-1:0] fixv_r  [2];
  logic [31:0]        zc      [2];
  logic [ANGLE_W-1:0] ang     [2];

  logic [ANGLE_W-1:0] abl_o, abr_o, atl_o, atr_o;
  logic [SIDE_W-1:0]  h_o;
  logic [PERIM_W-1:0] perim_o;
  logic [AREA_W-1:0]  area_o;
  logic               fault;

  // stall only when a result would otherwise be overwritten
  assign en        = !(out_valid_r && !out_tready && vld_r[NV-1]);
  assign in_tready = en;

  always_comb begin
    vld_nxt = {vld_r[NV-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= vld_nxt;
      end
      if (en && vld_r[NV-1]) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  tsfs_front u_front (
    .clk         (clk),
    .en          (en),
    .left_leg    (in_tdata[15:0]),
    .right_leg   (in_tdata[31:16]),
    .top_base    (in_tdata[47:32]),
    .bottom_base (in_tdata[63:48]),
    .fr_o        (fr)
  );

  always_comb begin
    side0.status = fr.status;
    side0.perim  = fr.perim;
    side0.s      = fr.s;
    side0.d      = fr.d;
    side0.lneg   = fr.lneg;
    side0.lmag   = fr.lmag;
    side0.rneg   = fr.rneg;
    side0.rmag   = fr.rmag;
    side0.h      = '0;
    side0.area   = '0;
  end

  // square root row
  assign sq_c[0].rad  = fr.num;
  assign sq_c[0].rem  = '0;
  assign sq_c[0].root = '0;

  for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
    tsfs_sqrt_cell u_cell (
      .clk  (clk),
      .en   (en),
      .sq_i (sq_c[j]),
      .sq_o (sq_c[j+1])
    );
  end

  assign y_root = sq_c[SQRT_CELLS].root;

  // height = floor(root / 2d)
  assign dv_c[0].rem = y_root;
  assign dv_c[0].dsh = {side_r[Y_STG].d, {SIDE_W{1'b0}}};
  assign dv_c[0].q   = '0;

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    tsfs_div_cell u_cell (
      .clk  (clk),
      .en   (en),
      .dv_i (dv_c[k]),
      .dv_o (dv_c[k+1])
    );
  end

  assign area_prod = {17'b0, dv_c[DIV_CELLS].q} * {16'b0, side_r[DIV_END].s};

  always_comb begin
    side_nxt[1] = side0;
    for (int n = 2; n <= FIN_STG; n++) begin
      side_nxt[n] = side_r[n-1];
    end
    side_nxt[AREA_STG].h    = dv_c[DIV_CELLS].q;
    side_nxt[AREA_STG].area = area_prod[AREA_W:1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 1; n <= FIN_STG; n++) begin
        side_r[n] <= side_nxt[n];
      end
    end
  end

  // angle lanes: 0 is bottom left, 1 is bottom right
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      vec_nxt[l].neg = (l == 0) ? side_r[Y_STG].lneg : side_r[Y_STG].rneg;
      vec_nxt[l].x   = {2'b0, ((l == 0) ? side_r[Y_STG].lmag : side_r[Y_STG].rmag)};
      vec_nxt[l].y   = {1'b0, y_root};
      vec_nxt[l].z   = '0;
      vec_nxt[l].fix = (y_root == '0) || (vec_nxt[l].x == '0);
      if (y_root == '0) begin
        vec_nxt[l].fixv = vec_nxt[l].neg ? DEG180 : '0;
      end else begin
        vec_nxt[l].fixv = DEG90;
      end
    end
  end

  // normalize until both components fit the cordic width
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < NORM_CELLS; k++) begin
        norm_nxt[k+1][l] = ln_r[k][l];
        if ((ln_r[k][l].x[LANE_W-1:NORM_BITS] | ln_r[k][l].y[LANE_W-1:NORM_BITS]) != '0)
        begin
          norm_nxt[k+1][l].x = ln_r[k][l].x >>> 1;
          norm_nxt[k+1][l].y = ln_r[k][l].y >>> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        ln_r[0][l] <= vec_nxt[l];
        for (int k = 0; k < NORM_CELLS; k++) begin
          ln_r[k+1][l] <= norm_nxt[k+1][l];
        end
      end
    end
  end

  // negative offset: rotate by a quarter turn first
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      pre_nxt[l] = ln_r[NORM_CELLS][l];
      if (ln_r[NORM_CELLS][l].neg) begin
        pre_nxt[l].x = ln_r[NORM_CELLS][l].y;
        pre_nxt[l].y = ln_r[NORM_CELLS][l].x;
        pre_nxt[l].z = Z_W'(1) <<< 30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r <= pre_nxt;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign cd_c[0][l] = pre_r[l];
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      tsfs_cordic_cell u_cell (
        .clk    (clk),
        .en     (en),
        .step_i (5'(i)),
        .ln_i   (cd_c[i][l]),
        .ln_o   (cd_c[i+1][l])
      );
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (cd_c[CORDIC_STEPS][l].z[Z_W-1]) begin
        zc[l] = '0;
      end else if (cd_c[CORDIC_STEPS][l].z > (Z_W'(1) <<< 31)) begin
        zc[l] = 32'h8000_0000;
      end else begin
        zc[l] = cd_c[CORDIC_STEPS][l].z[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        prod_r[l] <= {16'b0, zc[l]} * {32'b0, DEG180};
        fix_r[l]  <= cd_c[CORDIC_STEPS][l].fix;
        fixv_r[l] <= cd_c[CORDIC_STEPS][l].fixv;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ang[l] = fix_r[l] ? fixv_r[l] : prod_r[l][46:31];
    end
    fault   = side_r[FIN_STG].status != ST_OK;
    h_o     = fault ? '0 : side_r[FIN_STG].h;
    perim_o = fault ? '0 : side_r[FIN_STG].perim;
    area_o  = fault ? '0 : side_r[FIN_STG].area;
    abl_o   = fault ? '0 : ang[0];
    abr_o   = fault ? '0 : ang[1];
    atl_o   = fault ? '0 : DEG180 - ang[0];
    atr_o   = fault ? '0 : DEG180 - ang[1];
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[NV-1]) begin
      out_data_r <= {6'b0, atr_o, atl_o, abr_o, abl_o, area_o, perim_o, h_o};
      out_user_r <= side_r[FIN_STG].status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // a fault result carries no numbers
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r != ST_OK) |-> (out_data_r[129:0] == '0))
    else $error("fault result with nonzero fields");

  // top and bottom angles on one side are supplements
  a_supplement: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r == ST_OK) |->
      ((17'(out_data_r[81:66]) + 17'(out_data_r[113:98])) == 17'(DEG180)))
    else $error("left angles do not add to 180 degrees");

  // a full last stage that cannot drain holds its place
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NV-1] && !en) |=> (vld_r[NV-1] && out_valid_r))
    else $error("result dropped during stall");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[81:66] <= DEG180 && out_data_r[97:82] <= DEG180))
    else $error("bottom angle beyond 180 degrees");

endmodule
